FILE: design/crhni_pkg.sv
package crhni_pkg;

   localparam int REG_W   = 6;
   localparam int LAT_W   = 6;
   localparam int WORD_W  = 64;
   localparam int COUNT_W = 16;
   localparam int CYCLE_W = 32;
   localparam int EPOCH_W = 8;
   localparam int ENTRY_W = EPOCH_W + CYCLE_W;
   // widest table index the register count may need
   localparam int IDX_W   = 10;

   localparam logic [LAT_W-1:0]   LAT_RESET   = 6'd4;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX   = 8'hFF;

   typedef struct packed {
      logic [WORD_W-1:0] instr_word;
      logic              program_start;
      logic [REG_W-1:0]  read_a_reg;
      logic              read_a_valid;
      logic [REG_W-1:0]  read_b_reg;
      logic              read_b_valid;
      logic [REG_W-1:0]  write_a_reg;
      logic              write_a_valid;
      logic [REG_W-1:0]  write_b_reg;
      logic              write_b_valid;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  out_word;
      logic               is_nop;
      logic [COUNT_W-1:0] origin_index;
      logic [COUNT_W-1:0] out_position;
      logic               count_overflow;
      logic               last_of_run;
   } rsp_type;

   // one writer record: program epoch tag and issue cycle
   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [CYCLE_W-1:0] cycle;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0] ra;
      logic [IDX_W-1:0] rb;
      logic [IDX_W-1:0] wa;
      logic [IDX_W-1:0] wb;
   } store_rd_type;

   typedef struct packed {
      logic             en_a;
      logic             en_b;
      logic             clear;
      logic [IDX_W-1:0] addr_a;
      logic [IDX_W-1:0] addr_b;
      entry_type        value;
   } store_wr_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

endpackage

FILE: design/crhni_ram.sv
module crhni_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/crhni_store.sv
module crhni_store import crhni_pkg::*; #(
   parameter int NUM_CKE_REGS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  store_rd_type rd_cmd,
   input  store_wr_type wr_cmd,
   output entry_type    entry_a,
   output entry_type    entry_b
);

   localparam int AW = $clog2(NUM_CKE_REGS);

   // last cycle's writes, physical per bank and logical
   typedef struct packed {
      logic               en_a;
      logic               en_b;
      logic [IDX_W-1:0]   addr_a;
      logic [IDX_W-1:0]   addr_b;
      logic [ENTRY_W-1:0] data_a;
      logic [ENTRY_W-1:0] data_b;
      logic [ENTRY_W-1:0] value;
   } fwd_type;

   store_rd_type       rd_q_ff;
   fwd_type            fwd_ff;
   fwd_type            fwd_in;
   logic [ENTRY_W-1:0] a_ra, a_rb, a_wb;
   logic [ENTRY_W-1:0] b_ra, b_rb, b_wa;
   logic [ENTRY_W-1:0] a_phys_wb, b_phys_wa;
   logic [ENTRY_W-1:0] data_a, data_b;

   // logical value is bank A xor bank B, unless written last cycle
   function automatic logic [ENTRY_W-1:0] pick(input logic [IDX_W-1:0]   addr,
                                               input logic [ENTRY_W-1:0] a,
                                               input logic [ENTRY_W-1:0] b,
                                               input fwd_type            f);
      logic hit;
      hit = (f.en_a && (f.addr_a == addr)) || (f.en_b && (f.addr_b == addr));
      return hit ? f.value : (a ^ b);
   endfunction

   always_ff @(posedge clock) begin
      rd_q_ff <= rd_cmd;
      if (reset) begin
         fwd_ff.en_a <= 1'b0;
         fwd_ff.en_b <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   always_comb begin
      a_phys_wb = (fwd_ff.en_a && (fwd_ff.addr_a == rd_q_ff.wb)) ? fwd_ff.data_a : a_wb;
      b_phys_wa = (fwd_ff.en_b && (fwd_ff.addr_b == rd_q_ff.wa)) ? fwd_ff.data_b : b_wa;
      data_a    = wr_cmd.clear ? '0 : (wr_cmd.value ^ b_phys_wa);
      data_b    = wr_cmd.clear ? '0 : (wr_cmd.value ^ a_phys_wb);

      fwd_in.en_a   = wr_cmd.en_a;
      fwd_in.en_b   = wr_cmd.en_b;
      fwd_in.addr_a = wr_cmd.addr_a;
      fwd_in.addr_b = wr_cmd.addr_b;
      fwd_in.data_a = data_a;
      fwd_in.data_b = data_b;
      fwd_in.value  = wr_cmd.clear ? '0 : wr_cmd.value;

      entry_a = pick(rd_q_ff.ra, a_ra, b_ra, fwd_ff);
      entry_b = pick(rd_q_ff.rb, a_rb, b_rb, fwd_ff);
   end

   crhni_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_CKE_REGS)) u_a_ra (
      .clock(clock), .wr_en(wr_cmd.en_a), .wr_addr(wr_cmd.addr_a[AW-1:0]),
      .wr_data(data_a), .rd_addr(rd_cmd.ra[AW-1:0]), .rd_data(a_ra));

   crhni_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_CKE_REGS)) u_a_rb (
      .clock(clock), .wr_en(wr_cmd.en_a), .wr_addr(wr_cmd.addr_a[AW-1:0]),
      .wr_data(data_a), .rd_addr(rd_cmd.rb[AW-1:0]), .rd_data(a_rb));

   crhni_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_CKE_REGS)) u_a_wb (
      .clock(clock), .wr_en(wr_cmd.en_a), .wr_addr(wr_cmd.addr_a[AW-1:0]),
      .wr_data(data_a), .rd_addr(rd_cmd.wb[AW-1:0]), .rd_data(a_wb));

   crhni_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_CKE_REGS)) u_b_ra (
      .clock(clock), .wr_en(wr_cmd.en_b), .wr_addr(wr_cmd.addr_b[AW-1:0]),
      .wr_data(data_b), .rd_addr(rd_cmd.ra[AW-1:0]), .rd_data(b_ra));

   crhni_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_CKE_REGS)) u_b_rb (
      .clock(clock), .wr_en(wr_cmd.en_b), .wr_addr(wr_cmd.addr_b[AW-1:0]),
      .wr_data(data_b), .rd_addr(rd_cmd.rb[AW-1:0]), .rd_data(b_rb));

   crhni_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_CKE_REGS)) u_b_wa (
      .clock(clock), .wr_en(wr_cmd.en_b), .wr_addr(wr_cmd.addr_b[AW-1:0]),
      .wr_data(data_b), .rd_addr(rd_cmd.wa[AW-1:0]), .rd_data(b_wa));

endmodule

FILE: design/cke_raw_hazard_nop_inserter_unit.sv
// An accepted instruction is held in s1, then loaded into the response register; each NOP
// inserted ahead of it delays it. Throughput: one instruction per cycle without hazards and
// with rsp_stall low; each NOP uses an emit of the single emit stage that re-reads the
// writer table every cycle. Reset: synchronous; a clearing pass over all NUM_CKE_REGS
// entries runs before the first transfer. A program start that finds the epoch tag at its
// top value waits for another pass (the 255th program start after reset, then every 254th).
module cke_raw_hazard_nop_inserter_unit import crhni_pkg::*; #(
   parameter int NUM_CKE_REGS = 64,
   parameter int MAX_LATENCY  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LAT_W-1:0] csr_data
);

   localparam int AW = $clog2(NUM_CKE_REGS);

   state_type          state_ff, state_in;
   logic [AW-1:0]      sweep_ff, sweep_in;
   logic               s1_valid_ff, s1_valid_in;
   req_type            s1_ff, s1_in;
   logic [CYCLE_W-1:0] issue_ff, issue_in;
   logic [COUNT_W-1:0] src_ff, src_in;
   logic               ovf_ff, ovf_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [LAT_W-1:0]   lat_ff, lat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               rsp_free, emit, retire, hazard, wrap_clear, accept, stall;
   logic               hz_a, hz_b, over;
   logic [LAT_W-1:0]   lat_eff;
   logic [CYCLE_W-1:0] eff_issue, age_a, age_b;
   logic [COUNT_W-1:0] eff_src;
   logic [EPOCH_W-1:0] eff_epoch;
   logic [COUNT_W-1:0] pos;
   req_type            rd_src;
   store_rd_type       rd_cmd;
   store_wr_type       wr_cmd;
   entry_type          entry_a, entry_b;

   function automatic logic in_range(input logic [REG_W-1:0] r);
      return 32'(r) < 32'(NUM_CKE_REGS);
   endfunction

   crhni_store #(.NUM_CKE_REGS(NUM_CKE_REGS)) u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_cmd (rd_cmd),
      .wr_cmd (wr_cmd),
      .entry_a(entry_a),
      .entry_b(entry_b)
   );

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      // load only on emit; hold while the receiver stalls
      if (emit) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         issue_ff     <= '0;
         src_ff       <= '0;
         ovf_ff       <= 1'b0;
         epoch_ff     <= EPOCH_FIRST;
         lat_ff       <= LAT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         s1_valid_ff  <= s1_valid_in;
         issue_ff     <= issue_in;
         src_ff       <= src_in;
         ovf_ff       <= ovf_in;
         epoch_ff     <= epoch_in;
         lat_ff       <= lat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      issue_in     = issue_ff;
      src_in       = src_ff;
      ovf_in       = ovf_ff;
      epoch_in     = epoch_ff;
      lat_in       = (csr_valid && csr_ready) ? csr_data : lat_ff;
      wr_cmd       = '0;
      emit         = 1'b0;

      lat_eff = (32'(lat_ff) > 32'(MAX_LATENCY)) ? LAT_W'(MAX_LATENCY) : lat_ff;

      // a program start sees the cleared counters and a fresh epoch
      eff_issue = s1_ff.program_start ? '0 : issue_ff;
      eff_src   = s1_ff.program_start ? '0 : src_ff;
      eff_epoch = s1_ff.program_start ? epoch_ff + 1'b1 : epoch_ff;

      age_a = issue_ff - entry_a.cycle;
      age_b = issue_ff - entry_b.cycle;
      hz_a  = s1_ff.read_a_valid && in_range(s1_ff.read_a_reg) && !s1_ff.program_start
              && (entry_a.epoch == epoch_ff) && (age_a < CYCLE_W'(lat_eff));
      hz_b  = s1_ff.read_b_valid && in_range(s1_ff.read_b_reg) && !s1_ff.program_start
              && (entry_b.epoch == epoch_ff) && (age_b < CYCLE_W'(lat_eff));
      hazard = hz_a || hz_b;

      wrap_clear = s1_valid_ff && s1_ff.program_start && (epoch_ff == EPOCH_MAX);
      rsp_free   = !rsp_valid_ff || !rsp_stall;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_cmd.en_a   = 1'b1;
            wr_cmd.en_b   = 1'b1;
            wr_cmd.clear  = 1'b1;
            wr_cmd.addr_a = IDX_W'(sweep_ff);
            wr_cmd.addr_b = IDX_W'(sweep_ff);
            if (sweep_ff == AW'(NUM_CKE_REGS - 1)) begin
               state_in = ST_RUN;
               sweep_in = '0;
               epoch_in = EPOCH_FIRST;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_RUN: begin
            if (wrap_clear) begin
               state_in = ST_CLEAR;
            end else begin
               emit = s1_valid_ff && rsp_free;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      retire = emit && !hazard;
      stall  = (state_ff != ST_RUN) || (s1_valid_ff && !retire);
      accept = req_valid && !stall;

      // hold the read addresses of the waiting instruction so its table view stays current
      rd_src    = accept ? req_payload : s1_ff;
      rd_cmd.ra = IDX_W'(rd_src.read_a_reg);
      rd_cmd.rb = IDX_W'(rd_src.read_b_reg);
      rd_cmd.wa = IDX_W'(rd_src.write_a_reg);
      rd_cmd.wb = IDX_W'(rd_src.write_b_reg);

      s1_in       = accept ? req_payload : s1_ff;
      s1_valid_in = accept || (s1_valid_ff && !retire);

      over = ovf_ff && !s1_ff.program_start || (eff_issue >= CYCLE_W'(COUNT_MAX));
      pos  = over ? COUNT_MAX : eff_issue[COUNT_W-1:0];

      rsp_in.out_word       = hazard ? '0 : s1_ff.instr_word;
      rsp_in.is_nop         = hazard;
      rsp_in.origin_index   = hazard ? COUNT_MAX : eff_src;
      rsp_in.out_position   = pos;
      rsp_in.count_overflow = over;
      rsp_in.last_of_run    = !hazard;

      if (emit) begin
         issue_in = eff_issue + 1'b1;
         ovf_in   = over;
      end

      if (retire) begin
         src_in        = eff_src + 1'b1;
         epoch_in      = eff_epoch;
         wr_cmd.en_a   = s1_ff.write_a_valid && in_range(s1_ff.write_a_reg);
         wr_cmd.en_b   = s1_ff.write_b_valid && in_range(s1_ff.write_b_reg)
                         && !(wr_cmd.en_a && (s1_ff.write_a_reg == s1_ff.write_b_reg));
         wr_cmd.addr_a = IDX_W'(s1_ff.write_a_reg);
         wr_cmd.addr_b = IDX_W'(s1_ff.write_b_reg);
         wr_cmd.value  = '{epoch: eff_epoch, cycle: eff_issue};
      end

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   assign req_stall   = stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

endmodule
